/* hdl/multi_pool_slot_allocator_unit_assert.svh */
// Assertion macros used by the slot allocator's pool lane module.
`ifndef MULTI_POOL_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define MULTI_POOL_SLOT_ALLOCATOR_UNIT_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define MPSA_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("mpsa assertion failed");

// Condition that must hold in the cycle after the trigger.
`define MPSA_ASSERT_NEXT(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("mpsa assertion failed");

`endif

/* hdl/mpsa_pkg.sv */
// Types, codes and constants of the multi-pool slot allocator.
package mpsa_pkg;

    localparam int POOL_COUNT = 4;
    localparam int OWNER_W    = 8;   // width of the owner field
    localparam int REQ_W      = 4;   // width of one pool count in a request
    localparam int FREE_W     = 4;   // internal free count, pools up to 15 slots
    localparam int FREE_OUT_W = 3;   // free count as shown in a response

    localparam int DEF_PRINTER_SLOTS = 4;
    localparam int DEF_SCANNER_SLOTS = 4;
    localparam int DEF_MODEM_SLOTS   = 4;
    localparam int DEF_DISC_SLOTS    = 4;
    localparam int DEF_OWNER_BITS    = 8;

    typedef enum logic [0:0] {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        STATUS_GRANTED  = 2'd0,
        STATUS_REFUSED  = 2'd1,
        STATUS_RELEASED = 2'd2
    } status_t;

    typedef struct packed {
        opcode_t            opcode;
        logic [OWNER_W-1:0] owner_id;
        logic [REQ_W-1:0]   printer_request;
        logic [REQ_W-1:0]   scanner_request;
        logic [REQ_W-1:0]   modem_request;
        logic [REQ_W-1:0]   disc_request;
    } req_t;

    typedef struct packed {
        status_t               status;
        logic [FREE_OUT_W-1:0] printer_free;
        logic [FREE_OUT_W-1:0] scanner_free;
        logic [FREE_OUT_W-1:0] modem_free;
        logic [FREE_OUT_W-1:0] disc_free;
    } rsp_t;

    // Commit strobes from the merge stage to each pool lane
    typedef struct packed {
        logic alloc;
        logic rel;
    } lane_ctrl_t;

endpackage

/* hdl/multi_pool_slot_allocator_unit.sv */
// Top level: four pool lanes, merge of their shortage flags, response register.
// The response is registered: it is valid in the cycle after its request is accepted.
// Throughput: one request per cycle; all four lanes grant or release in that cycle,
// and a waiting response does not block the next request if it is taken that cycle.
// Reset: rst_n clears every busy bit and sets each free count to its pool size.
module multi_pool_slot_allocator_unit
    import mpsa_pkg::*;
#(
    parameter int PRINTER_SLOTS = DEF_PRINTER_SLOTS,
    parameter int SCANNER_SLOTS = DEF_SCANNER_SLOTS,
    parameter int MODEM_SLOTS   = DEF_MODEM_SLOTS,
    parameter int DISC_SLOTS    = DEF_DISC_SLOTS,
    parameter int OWNER_BITS    = DEF_OWNER_BITS
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  req_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output rsp_t out_data
);

    localparam int SLOTS_ARR [POOL_COUNT] =
        '{PRINTER_SLOTS, SCANNER_SLOTS, MODEM_SLOTS, DISC_SLOTS};

    logic                  accept;
    logic                  any_short;
    logic [OWNER_BITS-1:0] who;
    lane_ctrl_t            ctrl;
    logic [REQ_W-1:0]      want      [POOL_COUNT];
    logic [FREE_W-1:0]     free_next [POOL_COUNT];
    logic [POOL_COUNT-1:0] short_vec;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    rsp_t                  out_data_reg;
    rsp_t                  rsp_next;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign who      = OWNER_BITS'(in_data.owner_id);

    assign want[0] = in_data.printer_request;
    assign want[1] = in_data.scanner_request;
    assign want[2] = in_data.modem_request;
    assign want[3] = in_data.disc_request;

    // Pool lanes
    for (genvar g = 0; g < POOL_COUNT; g++)
    begin : g_lane
        mpsa_lane #(
            .SLOTS      (SLOTS_ARR[g]),
            .OWNER_BITS (OWNER_BITS)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .who       (who),
            .want      (want[g]),
            .short_of  (short_vec[g]),
            .free_next (free_next[g])
        );
    end

    // Merge: all-or-nothing grant across pools
    assign any_short  = |short_vec;
    assign ctrl.alloc = accept && (in_data.opcode == OP_ALLOC) && !any_short;
    assign ctrl.rel   = accept && (in_data.opcode == OP_RELEASE);

    // Response contents
    always_comb
    begin
        case (in_data.opcode)
            OP_RELEASE: rsp_next.status = STATUS_RELEASED;
            OP_ALLOC:   rsp_next.status = any_short ? STATUS_REFUSED : STATUS_GRANTED;
            default:    rsp_next.status = STATUS_REFUSED;
        endcase
        rsp_next.printer_free = free_next[0][FREE_OUT_W-1:0];
        rsp_next.scanner_free = free_next[1][FREE_OUT_W-1:0];
        rsp_next.modem_free   = free_next[2][FREE_OUT_W-1:0];
        rsp_next.disc_free    = free_next[3][FREE_OUT_W-1:0];
    end

    // Response valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= rsp_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* hdl/mpsa_lane.sv */
// One pool lane: busy bits, owners, free count, first-free grant and release match.
module mpsa_lane
    import mpsa_pkg::*;
#(
    parameter int SLOTS      = DEF_PRINTER_SLOTS,
    parameter int OWNER_BITS = DEF_OWNER_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lane_ctrl_t            ctrl,
    input  logic [OWNER_BITS-1:0] who,
    input  logic [REQ_W-1:0]      want,
    output logic                  short_of,
    output logic [FREE_W-1:0]     free_next
);

`include "multi_pool_slot_allocator_unit_assert.svh"

    logic [SLOTS-1:0]      busy_reg;
    logic [SLOTS-1:0]      busy_next;
    logic [OWNER_BITS-1:0] owner_reg [SLOTS];
    logic [FREE_W-1:0]     free_reg;
    logic [SLOTS-1:0]      free_vec;
    logic [SLOTS-1:0]      grant_vec;
    logic [SLOTS-1:0]      match_vec;
    logic [FREE_W-1:0]     freed;

    assign free_vec = ~busy_reg;
    assign short_of = (want > free_reg);

    // Grant a free slot when fewer than want free slots sit below it
    always_comb
    begin
        logic [SLOTS-1:0] below;
        for (int s = 0; s < SLOTS; s++)
        begin
            below = '0;
            for (int j = 0; j < s; j++)
            begin
                below[j] = free_vec[j];
            end
            grant_vec[s] = free_vec[s] && (FREE_W'($countones(below)) < want);
        end
    end

    // Slots held by the releasing owner
    always_comb
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            match_vec[s] = busy_reg[s] && (owner_reg[s] == who);
        end
    end

    assign freed = FREE_W'($countones(match_vec));

    // Next busy bits and free count
    always_comb
    begin
        busy_next = busy_reg;
        free_next = free_reg;
        if (ctrl.alloc)
        begin
            busy_next = busy_reg | grant_vec;
            free_next = free_reg - want;
        end
        else if (ctrl.rel)
        begin
            busy_next = busy_reg & ~match_vec;
            free_next = free_reg + freed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
            free_reg <= FREE_W'(SLOTS);
        end
        else
        begin
            busy_reg <= busy_next;
            free_reg <= free_next;
        end
    end

    // Owner entries are written only for newly granted slots
    always_ff @(posedge clk)
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            if (ctrl.alloc && grant_vec[s])
            begin
                owner_reg[s] <= who;
            end
        end
    end

    `MPSA_ASSERT(a_free_tracks_busy, free_reg == FREE_W'(SLOTS - $countones(busy_reg)))
    `MPSA_ASSERT(a_no_alloc_when_short, !(ctrl.alloc && short_of))
    `MPSA_ASSERT(a_single_commit, !(ctrl.alloc && ctrl.rel))
    `MPSA_ASSERT_NEXT(a_idle_holds_busy, !ctrl.alloc && !ctrl.rel, $stable(busy_reg))

endmodule

/* tb/sv/testbench.sv */
// Testbench for the multi-pool slot allocator: directed and random requests, scoreboard check.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mpsa_pkg::*;

    localparam int SLOT_MAX    = 16;
    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_REQS = 1000;
    localparam int IDLE_PCT    = 14;

    // Expected-response store and allocator predictor
    class allocation_scoreboard;
        bit                 busy   [POOL_COUNT][SLOT_MAX];
        logic [OWNER_W-1:0] holder [POOL_COUNT][SLOT_MAX];
        int unsigned        free_cnt  [POOL_COUNT];
        int unsigned        pool_size [POOL_COUNT];
        rsp_t               expected_q[$];
        int unsigned        mismatches;

        function new();
            pool_size = '{DEF_PRINTER_SLOTS, DEF_SCANNER_SLOTS,
                          DEF_MODEM_SLOTS, DEF_DISC_SLOTS};
            for (int p = 0; p < POOL_COUNT; p++)
            begin
                free_cnt[p] = pool_size[p];
                for (int s = 0; s < SLOT_MAX; s++)
                begin
                    busy[p][s]   = 1'b0;
                    holder[p][s] = '0;
                end
            end
            mismatches = 0;
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("mismatch at %0t: %s", $realtime, what);
        endtask

        function int pending();
            return expected_q.size();
        endfunction

        // Apply one request to the shadow pools, return the response it should give
        function rsp_t predict_response(req_t r);
            logic [OWNER_W-1:0] who;
            int unsigned        want [POOL_COUNT];
            int unsigned        left;
            bit                 short_of;
            rsp_t               rsp;
            who = r.owner_id & OWNER_W'((1 << DEF_OWNER_BITS) - 1);
            want = '{r.printer_request, r.scanner_request, r.modem_request, r.disc_request};
            if (r.opcode == OP_RELEASE)
            begin
                for (int p = 0; p < POOL_COUNT; p++)
                    for (int s = 0; s < pool_size[p]; s++)
                        if (busy[p][s] && holder[p][s] == who)
                        begin
                            busy[p][s] = 1'b0;
                            free_cnt[p]++;
                        end
                rsp.status = STATUS_RELEASED;
            end
            else
            begin
                short_of = 1'b0;
                for (int p = 0; p < POOL_COUNT; p++)
                    if (want[p] > free_cnt[p])
                        short_of = 1'b1;
                if (short_of)
                    rsp.status = STATUS_REFUSED;
                else
                begin
                    // lowest-numbered free slots first
                    for (int p = 0; p < POOL_COUNT; p++)
                    begin
                        left = want[p];
                        for (int s = 0; s < pool_size[p] && left > 0; s++)
                            if (!busy[p][s])
                            begin
                                busy[p][s]   = 1'b1;
                                holder[p][s] = who;
                                left--;
                            end
                        free_cnt[p] -= want[p];
                    end
                    rsp.status = STATUS_GRANTED;
                end
            end
            rsp.printer_free = FREE_OUT_W'(free_cnt[0]);
            rsp.scanner_free = FREE_OUT_W'(free_cnt[1]);
            rsp.modem_free   = FREE_OUT_W'(free_cnt[2]);
            rsp.disc_free    = FREE_OUT_W'(free_cnt[3]);
            return rsp;
        endfunction

        function void note_request(req_t r);
            expected_q.push_back(predict_response(r));
        endfunction

        task check_response(rsp_t got);
            rsp_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch("response with no request pending");
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.printer_free !== want.printer_free)
                report_mismatch($sformatf("printer_free %0d, expected %0d",
                                          got.printer_free, want.printer_free));
            if (got.scanner_free !== want.scanner_free)
                report_mismatch($sformatf("scanner_free %0d, expected %0d",
                                          got.scanner_free, want.scanner_free));
            if (got.modem_free !== want.modem_free)
                report_mismatch($sformatf("modem_free %0d, expected %0d",
                                          got.modem_free, want.modem_free));
            if (got.disc_free !== want.disc_free)
                report_mismatch($sformatf("disc_free %0d, expected %0d",
                                          got.disc_free, want.disc_free));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    req_t in_data;
    logic out_valid;
    logic out_ready;
    rsp_t out_data;

    bit          calm;
    int unsigned idle_cycles;

    allocation_scoreboard ledger = new();

    multi_pool_slot_allocator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        calm      = 1'b0;
    end

    always #6 clk = ~clk;

    // Response side: random back-pressure, none during the calm stretch
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Monitor both handshakes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                ledger.check_response(out_data);
            if (in_valid && in_ready)
                ledger.note_request(in_data);
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial
    begin
        idle_cycles = 0;
    end

    function automatic req_t make_req(opcode_t op, logic [OWNER_W-1:0] who,
                                      int unsigned pr, int unsigned sc,
                                      int unsigned mo, int unsigned di);
        req_t r;
        r.opcode          = op;
        r.owner_id        = who;
        r.printer_request = REQ_W'(pr);
        r.scanner_request = REQ_W'(sc);
        r.modem_request   = REQ_W'(mo);
        r.disc_request    = REQ_W'(di);
        return r;
    endfunction

    // Present one request from a falling edge until it is taken; returns at a falling edge
    task automatic send_request(req_t r);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Hold off new requests until every response is back
    task automatic drain_responses();
        in_valid <= 1'b0;
        while (ledger.pending() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        logic [OWNER_W-1:0] regulars [5];
        req_t               r;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty ask, release with nothing held, full pools, refusals, holes
        send_request(make_req(OP_ALLOC,   8'h00, 0, 0, 0, 0));
        send_request(make_req(OP_RELEASE, 8'h00, 15, 15, 15, 15));
        send_request(make_req(OP_ALLOC,   8'hFF, 4, 4, 4, 4));
        send_request(make_req(OP_ALLOC,   8'h01, 1, 0, 0, 0));
        send_request(make_req(OP_ALLOC,   8'h02, 0, 0, 0, 0));
        send_request(make_req(OP_RELEASE, 8'hFF, 0, 0, 0, 0));
        send_request(make_req(OP_ALLOC,   8'h01, 15, 15, 15, 15));
        send_request(make_req(OP_ALLOC,   8'h01, 5, 0, 0, 0));
        send_request(make_req(OP_ALLOC,   8'h01, 0, 0, 0, 8));
        send_request(make_req(OP_ALLOC,   8'h0F, 1, 2, 3, 4));
        send_request(make_req(OP_ALLOC,   8'hF0, 3, 2, 1, 0));
        send_request(make_req(OP_ALLOC,   8'hAA, 0, 0, 0, 0));
        send_request(make_req(OP_RELEASE, 8'h55, 7, 9, 10, 12));
        send_request(make_req(OP_RELEASE, 8'h0F, 0, 0, 0, 0));
        send_request(make_req(OP_ALLOC,   8'hAA, 1, 1, 1, 1));
        send_request(make_req(OP_ALLOC,   8'h80, 0, 1, 2, 4));
        send_request(make_req(OP_RELEASE, 8'hF0, 0, 0, 0, 0));
        send_request(make_req(OP_RELEASE, 8'hF0, 0, 0, 0, 0));
        send_request(make_req(OP_ALLOC,   8'h7F, 3, 0, 0, 0));
        send_request(make_req(OP_RELEASE, 8'hAA, 0, 0, 0, 0));
        send_request(make_req(OP_RELEASE, 8'h7F, 0, 0, 0, 0));
        send_request(make_req(OP_RELEASE, 8'h80, 0, 0, 0, 0));
        drain_responses();
        @(negedge clk);

        for (int i = 0; i < 5; i++)
            regulars[i] = OWNER_W'($urandom_range(255));

        // Random: mostly small asks and releases by a few regular owners, some noise
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            calm = (n >= 400 && n < 600);
            if (n == 700)
            begin
                drain_responses();
                @(negedge clk);
            end
            if ($urandom_range(99) < 85)
            begin
                if ($urandom_range(99) < 30)
                    r = make_req(OP_RELEASE, regulars[$urandom_range(4)],
                                 $urandom_range(15), $urandom_range(15),
                                 $urandom_range(15), $urandom_range(15));
                else
                    r = make_req(OP_ALLOC, regulars[$urandom_range(4)],
                                 $urandom_range(2), $urandom_range(2),
                                 $urandom_range(2), $urandom_range(2));
            end
            else
                r = make_req(opcode_t'($urandom_range(1)), OWNER_W'($urandom_range(255)),
                             $urandom_range(15), $urandom_range(15),
                             $urandom_range(15), $urandom_range(15));
            send_request(r);
        end
        calm = 1'b0;

        // Wind down: all responses back, then a quiet stretch before the final check.
        drain_responses();
        repeat (4) @(negedge clk);
        while (ledger.pending() != 0)
        begin
            ledger.report_mismatch("expected response never arrived");
            void'(ledger.expected_q.pop_front());
        end

        if (ledger.mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/mpsa_pkg.sv
hdl/mpsa_lane.sv
hdl/multi_pool_slot_allocator_unit.sv
tb/sv/testbench.sv
